/* hw/rtl/es2c_pkg.sv */
// es2c_pkg: shared types, constants and tables for the epoch seconds to calendar block.
// Used by es2c_cmpsub, epoch_seconds_to_calendar and both testbench files. No dependencies.
package es2c_pkg;

  // Compare/subtract unit width, remainder width and shared multiplier width
  localparam int unsigned CS_W  = 12;
  localparam int unsigned REM_W = CS_W - 1;
  localparam int unsigned MUL_W = 32;

  // Divisors, at multiplier width
  localparam logic [MUL_W-1:0] SEC_PER_MIN    = 32'd60;
  localparam logic [MUL_W-1:0] HOURS_PER_DAY  = 32'd24;
  localparam logic [MUL_W-1:0] DAYS_PER_WEEK  = 32'd7;
  localparam logic [MUL_W-1:0] DAYS_PER_CYCLE = 32'd1461;

  // Year lengths, at compare unit width
  localparam logic [CS_W-1:0] DAYS_PER_YEAR = 12'd365;
  localparam logic [CS_W-1:0] DAYS_PER_LEAP = 12'd366;

  // Reciprocals: quotient = (x * R) >> shift, exact over the noted input range
  localparam logic [MUL_W-1:0] RECIP_15   = 32'd1145324613;  // x < 2^30, shift 34
  localparam logic [MUL_W-1:0] RECIP_3    = 32'd1431655766;  // x < 2^30, shift 32
  localparam logic [MUL_W-1:0] RECIP_7    = 32'd74899;       // x < 2^16, shift 19
  localparam logic [MUL_W-1:0] RECIP_1461 = 32'd91868;       // x < 2^16, shift 27

  localparam logic [3:0]       OFFSET_RESET    = 4'd8;
  localparam logic [MUL_W-1:0] EPOCH_WEEKDAY   = 32'd4;   // 1970-01-01 was a Thursday
  localparam logic [7:0]       BASE_YEAR       = 8'd70;
  localparam logic [7:0]       LAST_VALID_YEAR = 8'd199;
  localparam logic [3:0]       LAST_MONTH      = 4'd11;
  localparam logic [3:0]       FEBRUARY        = 4'd1;
  localparam logic [1:0]       LAST_CYCLE_YEAR = 2'd3;
  localparam logic [1:0]       LEAP_CYCLE_YEAR = 2'd2;    // 1972 sits third in the cycle

  // Sequencer: each division is a quotient state and a remainder state
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_Q,
    ST_SEC_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_WDAY_Q,
    ST_WDAY_R,
    ST_CYC_Q,
    ST_CYC_R,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CS_W-1:0] a;
    logic [CS_W-1:0] b;
  } cs_req_t;

  typedef struct packed {
    logic            ge;
    logic [CS_W-1:0] diff;
  } cs_rsp_t;

  // Month length table, February stretched in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/es2c_cmpsub.sv */
// es2c_cmpsub: shared compare and subtract unit (a >= b, a - b).
// Depends on es2c_pkg for the request/response types.
module es2c_cmpsub (
  input  es2c_pkg::cs_req_t req,
  output es2c_pkg::cs_rsp_t rsp
);
  import es2c_pkg::*;

  logic [CS_W:0] wide;

  // One subtract; the borrow gives the compare
  assign wide     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.ge   = ~wide[CS_W];
  assign rsp.diff = wide[CS_W-1:0];

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// epoch_seconds_to_calendar: top level, sequencer and datapath registers.
// Depends on es2c_pkg and es2c_cmpsub.
//
// Converts a 32-bit Unix second count into local calendar fields, adding a
// whole-hour offset (register reset to 8). One word is handled at a time:
// in_ready is high only while the block is idle, and the result is held on
// the out_ port until taken. The divisions by 60, 60, 24, 7 and 1461 each
// run a quotient step and a remainder step on one shared 32x32 multiplier:
// a reciprocal multiply gives the quotient, then quotient times divisor is
// taken off the dividend in the 12-bit compare and subtract unit to give
// the remainder. The same subtract unit then walks up to four years and up
// to twelve months, one per cycle. Dates past 2099 still follow the
// every-fourth-year leap rule and raise out_beyond_range. Write the offset
// register only while idle.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_utc_offset_hours,
  // input word
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  // result word
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [7:0]  out_years_since_1900,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic        out_beyond_range
);
  import es2c_pkg::*;

  state_t              state_r, state_nxt;
  logic [3:0]          off_r;
  logic [MUL_W-1:0]    num_r;
  logic [MUL_W-1:0]    quo_r;
  logic [5:0]          sec_r, min_r;
  logic [4:0]          hour_r;
  logic [2:0]          wday_r;
  logic [15:0]         days_r;
  logic [5:0]          cyc_r;
  logic [REM_W-1:0]    rest_r;
  logic [1:0]          yi_r;
  logic [8:0]          yday_r;
  logic [3:0]          mon_r;

  cs_req_t             cs_req;
  cs_rsp_t             cs_rsp;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  prod;
  logic                in_fire, out_fire;
  logic                leap, year_done, month_done;
  logic [7:0]          year;

  es2c_cmpsub u_cmpsub (
    .req (cs_req),
    .rsp (cs_rsp)
  );

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  // Shared multiplier, full-width unsigned product
  assign prod = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

  // Year and month walks
  assign leap       = (yi_r == LEAP_CYCLE_YEAR);
  assign year_done  = (yi_r == LAST_CYCLE_YEAR) || !cs_rsp.ge;
  assign month_done = (mon_r == LAST_MONTH) || !cs_rsp.ge;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SEC_Q;
      ST_SEC_Q:  state_nxt = ST_SEC_R;
      ST_SEC_R:  state_nxt = ST_MIN_Q;
      ST_MIN_Q:  state_nxt = ST_MIN_R;
      ST_MIN_R:  state_nxt = ST_HOUR_Q;
      ST_HOUR_Q: state_nxt = ST_HOUR_R;
      ST_HOUR_R: state_nxt = ST_WDAY_Q;
      ST_WDAY_Q: state_nxt = ST_WDAY_R;
      ST_WDAY_R: state_nxt = ST_CYC_Q;
      ST_CYC_Q:  state_nxt = ST_CYC_R;
      ST_CYC_R:  state_nxt = ST_YEAR;
      ST_YEAR:   if (year_done) state_nxt = ST_MONTH;
      ST_MONTH:  if (month_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and shared unit operands.
  // Remainder cycles: dividend low bits minus low bits of quotient * divisor.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mul_a     = quo_r;
    mul_b     = '0;
    cs_req.a  = num_r[CS_W-1:0];
    cs_req.b  = prod[CS_W-1:0];
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SEC_Q, ST_MIN_Q: begin
        mul_a = {2'b00, num_r[MUL_W-1:2]};
        mul_b = RECIP_15;
      end
      ST_HOUR_Q: begin
        mul_a = {3'b000, num_r[MUL_W-1:3]};
        mul_b = RECIP_3;
      end
      ST_WDAY_Q: begin
        mul_a = num_r;
        mul_b = RECIP_7;
      end
      ST_CYC_Q: begin
        mul_a = num_r;
        mul_b = RECIP_1461;
      end
      ST_SEC_R, ST_MIN_R: mul_b = SEC_PER_MIN;
      ST_HOUR_R:          mul_b = HOURS_PER_DAY;
      ST_WDAY_R:          mul_b = DAYS_PER_WEEK;
      ST_CYC_R:           mul_b = DAYS_PER_CYCLE;
      ST_YEAR: begin
        cs_req.a = {1'b0, rest_r};
        cs_req.b = leap ? DAYS_PER_LEAP : DAYS_PER_YEAR;
      end
      ST_MONTH: begin
        cs_req.a = {1'b0, rest_r};
        cs_req.b = {{(CS_W-5){1'b0}}, month_len(mon_r, leap)};
      end
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      off_r   <= OFFSET_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) off_r <= cfg_utc_offset_hours;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) num_r <= in_epoch_seconds;
      end
      // quotients: (x/4)/15, (x/8)/3, x/7, x/1461
      ST_SEC_Q, ST_MIN_Q: quo_r <= {2'b00, prod[63:34]};
      ST_HOUR_Q:          quo_r <= prod[63:32];
      ST_WDAY_Q:          quo_r <= prod[50:19];
      ST_CYC_Q:           quo_r <= prod[58:27];
      ST_SEC_R: begin
        sec_r <= cs_rsp.diff[5:0];
        num_r <= quo_r;
      end
      ST_MIN_R: begin
        min_r <= cs_rsp.diff[5:0];
        num_r <= quo_r + {28'd0, off_r};
      end
      ST_HOUR_R: begin
        hour_r <= cs_rsp.diff[4:0];
        days_r <= quo_r[15:0];
        num_r  <= quo_r + EPOCH_WEEKDAY;
      end
      ST_WDAY_R: begin
        wday_r <= cs_rsp.diff[2:0];
        num_r  <= {16'd0, days_r};
      end
      ST_CYC_R: begin
        cyc_r  <= quo_r[5:0];
        rest_r <= cs_rsp.diff[REM_W-1:0];
        yi_r   <= '0;
      end
      ST_YEAR: begin
        if (!year_done) begin
          rest_r <= cs_rsp.diff[REM_W-1:0];
          yi_r   <= yi_r + 2'd1;
        end else begin
          yday_r <= rest_r[8:0];
          mon_r  <= '0;
        end
      end
      ST_MONTH: begin
        if (!month_done) begin
          rest_r <= cs_rsp.diff[REM_W-1:0];
          mon_r  <= mon_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // Result fields
  assign year                 = {cyc_r, yi_r} + BASE_YEAR;
  assign cfg_ready            = 1'b1;
  assign out_second           = sec_r;
  assign out_minute           = min_r;
  assign out_hour             = hour_r;
  assign out_weekday          = wday_r;
  assign out_years_since_1900 = year;
  assign out_day_of_year      = yday_r;
  assign out_month            = mon_r;
  assign out_day_of_month     = rest_r[4:0] + 5'd1;
  assign out_beyond_range     = (year > LAST_VALID_YEAR);

  // Checks
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SEC_Q))
    else $error("division not started after input accept");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SEC_R) || (state_r == ST_MIN_R)) |->
      (cs_rsp.diff < SEC_PER_MIN[CS_W-1:0]))
    else $error("second or minute remainder out of range");

  a_cyc_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CYC_R) |-> (cs_rsp.diff < DAYS_PER_CYCLE[CS_W-1:0]))
    else $error("day within four-year cycle out of range");

  a_year_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> (rest_r < DAYS_PER_LEAP[REM_W-1:0]))
    else $error("day of year out of range after year walk");

  a_month_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month <= LAST_MONTH) && (out_day_of_month != 5'd0))
    else $error("month or day of month out of range");

endmodule

/* tb/epoch_calendar_checker.sv */
// epoch_calendar_checker: watches the config, input and result channels of
// epoch_seconds_to_calendar, predicts each calendar word and compares it.
// Depends on es2c_pkg for the offset reset value.
module epoch_calendar_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_utc_offset_hours,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_second,
  input  logic [5:0]  out_minute,
  input  logic [4:0]  out_hour,
  input  logic [2:0]  out_weekday,
  input  logic [7:0]  out_years_since_1900,
  input  logic [8:0]  out_day_of_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day_of_month,
  input  logic        out_beyond_range,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import es2c_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;
  // Month lengths, January in the low bits, five bits each
  localparam logic [12*5-1:0] MONTH_LENGTHS = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                               5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic       beyond_range;
  } calendar_t;

  typedef struct packed {
    logic [31:0] epoch;
    calendar_t   cal;
  } due_word_t;

  due_word_t  due_dates [$];
  logic [3:0] zone_offset = OFFSET_RESET;
  int         fail_count = 0;
  int         due_count = 0;

  assign mismatches  = fail_count;
  assign outstanding = due_count;

  // Epoch seconds plus whole-hour offset -> local calendar fields.
  // Four-year cycles with the third year leap, even past 2099.
  function automatic calendar_t to_calendar(input logic [31:0] secs, input logic [3:0] offs);
    longint unsigned t, mins, hours, days, cycles, rest, year;
    int unsigned     yr, mon, mon_len;
    logic            leap;
    calendar_t       c;
    t         = {32'd0, secs};
    c.second  = 6'(t % 60);
    mins      = t / 60;
    c.minute  = 6'(mins % 60);
    hours     = mins / 60 + {60'd0, offs};
    c.hour    = 5'(hours % 24);
    days      = hours / 24;
    c.weekday = 3'((days + 4) % 7);   // day zero was a Thursday
    cycles    = days / 1461;
    rest      = days % 1461;
    yr = 0;
    while (yr < 3 && rest >= ((yr == 2) ? 366 : 365)) begin
      rest -= (yr == 2) ? 366 : 365;
      yr++;
    end
    leap = (yr == 2);
    year = cycles * 4 + yr + 70;
    c.years_since_1900 = year[7:0];
    c.day_of_year      = rest[8:0];
    c.beyond_range     = (year > 199);
    mon = 0;
    mon_len = {27'd0, MONTH_LENGTHS[4:0]};
    while (mon < 11 && rest >= mon_len) begin
      rest -= mon_len;
      mon++;
      mon_len = {27'd0, MONTH_LENGTHS[mon*5 +: 5]} + ((mon == 1 && leap) ? 1 : 0);
    end
    c.month        = mon[3:0];
    c.day_of_month = 5'(rest + 1);
    return c;
  endfunction

  function automatic string fmt_cal(input calendar_t c);
    return $sformatf("%0d/%0d/%0d %0d:%0d:%0d wday %0d yday %0d beyond %0b",
                     1900 + c.years_since_1900, c.month, c.day_of_month,
                     c.hour, c.minute, c.second, c.weekday, c.day_of_year,
                     c.beyond_range);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Track config, queue predictions, compare results in order
  always @(posedge clk) begin
    due_word_t entry;
    calendar_t got;
    if (!rst_n) begin
      zone_offset <= OFFSET_RESET;
      due_dates.delete();
      due_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) zone_offset <= cfg_utc_offset_hours;
      if (in_valid && in_ready) begin
        entry.epoch = in_epoch_seconds;
        entry.cal   = to_calendar(in_epoch_seconds, zone_offset);
        due_dates.push_back(entry);
      end
      if (out_valid && out_ready) begin
        got = {out_second, out_minute, out_hour, out_weekday, out_years_since_1900,
               out_day_of_year, out_month, out_day_of_month, out_beyond_range};
        if (due_dates.size() == 0) begin
          note_failure($sformatf("result word with nothing expected: %s", fmt_cal(got)));
        end else begin
          entry = due_dates.pop_front();
          if (got !== entry.cal)
            note_failure($sformatf("epoch %0d: expected %s, got %s", entry.epoch,
                                   fmt_cal(entry.cal), fmt_cal(got)));
        end
      end
      due_count <= due_dates.size();
    end
  end

endmodule

/* tb/epoch_seconds_to_calendar_tb.sv */
// epoch_seconds_to_calendar_tb: clock, reset, stimulus and verdict for the block.
// Depends on es2c_pkg, epoch_seconds_to_calendar and epoch_calendar_checker.
module epoch_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import es2c_pkg::*;

  localparam int          NUM_PHASES    = 8;
  localparam int          WORDS_PER_PHASE = 150;
  localparam int          DRAIN_CYCLES  = 150;
  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam logic [31:0] LAST_VALID_SEC = 32'd4102444799;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_utc_offset_hours = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [7:0]  out_years_since_1900;
  logic [8:0]  out_day_of_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic        out_beyond_range;
  int          mismatches;
  int          outstanding;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int zone_hours = int'(OFFSET_RESET);

  // Landmarks under the reset offset of +8: field extremes, local midnights,
  // leap days, the last valid second and the first dates past 2099.
  logic [31:0] landmarks [$] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
    32'd57599, 32'd57600,            // local day roll
    32'd31507199, 32'd31507200,      // first local new year
    32'd68140800, 32'd68198400,      // 1972 Feb 29, local midnight and 16:00
    32'd94579200,                    // last day of a leap year
    32'd951753600,                   // 2000 Feb 29
    32'd4102415999, 32'd4102416000,  // last valid local second and the next
    32'd4107513600,                  // 2100 Feb 29 under the four-year rule
    LAST_VALID_SEC,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
  };

  always #6 clk = ~clk;

  epoch_seconds_to_calendar i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_utc_offset_hours (cfg_utc_offset_hours),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_weekday          (out_weekday),
    .out_years_since_1900 (out_years_since_1900),
    .out_day_of_year      (out_day_of_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_beyond_range     (out_beyond_range)
  );

  epoch_calendar_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_utc_offset_hours (cfg_utc_offset_hours),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_weekday          (out_weekday),
    .out_years_since_1900 (out_years_since_1900),
    .out_day_of_year      (out_day_of_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_beyond_range     (out_beyond_range),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  // Result side backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the handshake
  task automatic send_epoch(input logic [31:0] secs);
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_offset(input logic [3:0] hours);
    cfg_valid            <= 1'b1;
    cfg_utc_offset_hours <= hours;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    zone_hours = int'(hours);
  endtask

  initial begin
    logic [31:0]    secs;
    longint signed  near;
    int             pick;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Offset for this phase: reset value first, then both extremes and 14, then random
      if (phase != 0) begin
        while (outstanding != 0) @(posedge clk);
        @(negedge clk);
        case (phase)
          1:       write_offset(4'd0);
          2:       write_offset(4'd15);
          3:       write_offset(4'd14);
          default: write_offset(4'($urandom_range(0, 15)));
        endcase
      end
      case (phase % 4)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 66; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 66; end
        default: begin sender_idle_pct = 11; stall_pct = 11; end
      endcase

      if (phase == 0) begin
        foreach (landmarks[i]) send_epoch(landmarks[i]);
      end

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          secs = $urandom();
        end else if (pick < 6) begin
          secs = $urandom_range(0, LAST_VALID_SEC);
        end else if (pick < 9) begin
          // a few seconds around some local midnight
          near = longint'($urandom_range(0, 49710)) * 86400 - zone_hours * 3600
                 + $urandom_range(0, 4) - 2;
          secs = near[31:0];
        end else begin
          secs = $urandom_range(32'd4000000000, 32'hFFFF_FFFF);
        end
        while ($urandom_range(0, 99) < sender_idle_pct) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
        send_epoch(secs);
      end
      in_valid <= 1'b0;
    end

    // Drain, then give the block time to show anything unexpected
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* epoch_seconds_to_calendar.f */
hw/rtl/es2c_pkg.sv
hw/rtl/es2c_cmpsub.sv
hw/rtl/epoch_seconds_to_calendar.sv
tb/epoch_calendar_checker.sv
tb/epoch_seconds_to_calendar_tb.sv
